### rtl/i2c_register_transaction_sequencer_assert.svh
// assertion macros used by the i2c register transaction sequencer fsm
// expects a clock named clk and an active high reset named rst in scope
`ifndef I2C_REGISTER_TRANSACTION_SEQUENCER_ASSERT_SVH
`define I2C_REGISTER_TRANSACTION_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define I2C_RTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define I2C_RTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/i2c_rts_pkg.sv
// types and constants of the i2c register transaction sequencer
// no dependencies
package i2c_rts_pkg;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_EVENT = 2'd2
  } req_type_t;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_SEND    = 3'd2,
    CMD_RESTART = 3'd3,
    CMD_RECV    = 3'd4,
    CMD_STOP    = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_START_FAIL   = 3'd1,
    ST_ADDR_NACK    = 3'd2,
    ST_REG_NACK     = 3'd3,
    ST_DATA_NACK    = 3'd4,
    ST_RESTART_FAIL = 3'd5,
    ST_RD_ADDR_NACK = 3'd6
  } status_t;

  // engine status codes
  localparam logic [7:0] BUS_START_OK   = 8'h08;
  localparam logic [7:0] BUS_RESTART_OK = 8'h10;
  localparam logic [7:0] BUS_SLA_W_NACK = 8'h20;
  localparam logic [7:0] BUS_DATA_NACK  = 8'h30;
  localparam logic [7:0] BUS_SLA_R_NACK = 8'h48;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] slave_address;
    logic [7:0] reg_address;
    logic [7:0] write_data;
    logic [7:0] bus_status;
    logic [7:0] received_byte;
  } item_t;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] tx_byte;
    logic       done_res;
    status_t    status;
    logic [7:0] read_data;
  } result_t;

endpackage

### rtl/i2c_rts_if.sv
// valid/ready channel interfaces for request and result beats
// no dependencies
interface i2c_rts_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] slave_address;
  logic [7:0] reg_address;
  logic [7:0] write_data;
  logic [7:0] bus_status;
  logic [7:0] received_byte;

  modport source (output valid, req_type, slave_address, reg_address, write_data,
                  bus_status, received_byte, input ready);
  modport sink (input valid, req_type, slave_address, reg_address, write_data,
                bus_status, received_byte, output ready);
endinterface

interface i2c_rts_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] tx_byte;
  logic       done_res;
  logic [2:0] status;
  logic [7:0] read_data;

  modport source (output valid, command, tx_byte, done_res, status, read_data,
                  input ready);
  modport sink (input valid, command, tx_byte, done_res, status, read_data,
                output ready);
endinterface

### rtl/i2c_rts_fsm.sv
// transaction phase register, held request bytes and next-command logic
// depends on i2c_rts_pkg and the assertion macro header
`include "i2c_register_transaction_sequencer_assert.svh"

module i2c_rts_fsm (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  i2c_rts_pkg::item_t item,
  output i2c_rts_pkg::result_t result
);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_START   = 3'd1,
    PH_SLA_W   = 3'd2,
    PH_REG     = 3'd3,
    PH_DATA    = 3'd4,
    PH_RESTART = 3'd5,
    PH_SLA_R   = 3'd6,
    PH_RECV    = 3'd7
  } phase_t;

  phase_t     phase;
  phase_t     phase_next;
  logic       is_read;
  logic [7:0] held_slave_address;
  logic [7:0] held_reg_address;
  logic [7:0] held_write_data;
  logic       load;

  assign load = (item.req_type == i2c_rts_pkg::REQ_WRITE ||
                 item.req_type == i2c_rts_pkg::REQ_READ) && phase == PH_IDLE;

  always_comb begin
    phase_next       = phase;
    result           = '0;
    result.command   = i2c_rts_pkg::CMD_NONE;
    result.status    = i2c_rts_pkg::ST_OK;
    case (item.req_type)
      i2c_rts_pkg::REQ_WRITE, i2c_rts_pkg::REQ_READ: begin
        if (phase == PH_IDLE) begin
          phase_next     = PH_START;
          result.command = i2c_rts_pkg::CMD_START;
        end
      end
      i2c_rts_pkg::REQ_EVENT: begin
        // abort paths below all fall through to the common stop at the end
        case (phase)
          PH_START: begin
            if (item.bus_status != i2c_rts_pkg::BUS_START_OK) begin
              result.status = i2c_rts_pkg::ST_START_FAIL;
            end else begin
              phase_next     = PH_SLA_W;
              result.command = i2c_rts_pkg::CMD_SEND;
              result.tx_byte = held_slave_address;
            end
          end
          PH_SLA_W: begin
            if (item.bus_status == i2c_rts_pkg::BUS_SLA_W_NACK) begin
              result.status = i2c_rts_pkg::ST_ADDR_NACK;
            end else begin
              phase_next     = PH_REG;
              result.command = i2c_rts_pkg::CMD_SEND;
              result.tx_byte = held_reg_address;
            end
          end
          PH_REG: begin
            if (item.bus_status == i2c_rts_pkg::BUS_DATA_NACK) begin
              result.status = i2c_rts_pkg::ST_REG_NACK;
            end else if (is_read) begin
              phase_next     = PH_RESTART;
              result.command = i2c_rts_pkg::CMD_RESTART;
            end else begin
              phase_next     = PH_DATA;
              result.command = i2c_rts_pkg::CMD_SEND;
              result.tx_byte = held_write_data;
            end
          end
          PH_DATA: begin
            if (item.bus_status == i2c_rts_pkg::BUS_DATA_NACK) begin
              result.status = i2c_rts_pkg::ST_DATA_NACK;
            end
          end
          PH_RESTART: begin
            if (item.bus_status != i2c_rts_pkg::BUS_RESTART_OK) begin
              result.status = i2c_rts_pkg::ST_RESTART_FAIL;
            end else begin
              phase_next     = PH_SLA_R;
              result.command = i2c_rts_pkg::CMD_SEND;
              result.tx_byte = {held_slave_address[7:1], 1'b1};
            end
          end
          PH_SLA_R: begin
            if (item.bus_status == i2c_rts_pkg::BUS_SLA_R_NACK) begin
              result.status = i2c_rts_pkg::ST_RD_ADDR_NACK;
            end else begin
              phase_next     = PH_RECV;
              result.command = i2c_rts_pkg::CMD_RECV;
            end
          end
          PH_RECV: begin
            result.read_data = item.received_byte;
          end
          default: begin
          end
        endcase
        // any event that did not advance the phase ends the transaction
        if (phase != PH_IDLE && phase_next == phase) begin
          phase_next      = PH_IDLE;
          result.command  = i2c_rts_pkg::CMD_STOP;
          result.done_res = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      is_read <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      if (load) begin
        is_read <= (item.req_type == i2c_rts_pkg::REQ_READ);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && load) begin
      held_slave_address <= item.slave_address;
      held_reg_address   <= item.reg_address;
      held_write_data    <= (item.req_type == i2c_rts_pkg::REQ_READ) ? 8'h00
                                                                     : item.write_data;
    end
  end

  `I2C_RTS_ASSERT_NEXT(a_req_starts, accept && load, phase == PH_START,
    "accepted request while idle did not enter start phase")
  `I2C_RTS_ASSERT_NEXT(a_hold_phase, !accept, $stable(phase) && $stable(is_read),
    "phase changed without an accepted beat")
  `I2C_RTS_ASSERT_NOW(a_done_stop, result.done_res,
    result.command == i2c_rts_pkg::CMD_STOP && phase_next == PH_IDLE,
    "transaction end without stop")
  `I2C_RTS_ASSERT_NOW(a_err_done, result.status != i2c_rts_pkg::ST_OK ||
    result.read_data != 8'h00, result.done_res,
    "error code or read data on a non-final result")

endmodule

### rtl/i2c_rts_out_reg.sv
// result register stage driving the result channel
// depends on i2c_rts_pkg and i2c_rts_res_if
module i2c_rts_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  i2c_rts_pkg::result_t in_result,
  i2c_rts_res_if.source        res
);

  logic                 valid;
  i2c_rts_pkg::result_t data;

  // a held result can be replaced in the same cycle it is taken
  assign in_ready = !valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= in_result;
    end
  end

  assign res.valid     = valid;
  assign res.command   = data.command;
  assign res.tx_byte   = data.tx_byte;
  assign res.done_res  = data.done_res;
  assign res.status    = data.status;
  assign res.read_data = data.read_data;

endmodule

### rtl/i2c_register_transaction_sequencer.sv
// Sequences single-byte I2C register writes and reads over a byte engine. Every
// request or engine completion beat gives exactly one result beat naming the
// next engine command, in the cycle after acceptance. One beat is taken per clock:
// the sequencer state and the next-command logic sit in front of a single result
// register, so a new beat is accepted whenever that register is empty or being
// read in the same cycle. Requests while busy and events while idle answer with
// command none.
// depends on i2c_rts_pkg, i2c_rts_if, i2c_rts_fsm and i2c_rts_out_reg
module i2c_register_transaction_sequencer (
  input  logic           clk,
  input  logic           rst,
  i2c_rts_req_if.sink    req,
  i2c_rts_res_if.source  res
);

  logic                 ready;
  logic                 accept;
  i2c_rts_pkg::item_t   item;
  i2c_rts_pkg::result_t result;

  assign req.ready = ready;
  assign accept    = req.valid && ready;

  assign item.req_type      = req.req_type;
  assign item.slave_address = req.slave_address;
  assign item.reg_address   = req.reg_address;
  assign item.write_data    = req.write_data;
  assign item.bus_status    = req.bus_status;
  assign item.received_byte = req.received_byte;

  i2c_rts_fsm u_fsm (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .result (result)
  );

  i2c_rts_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (ready),
    .in_result (result),
    .res       (res)
  );

endmodule

### bench/i2c_register_transaction_sequencer_test.sv
// testbench of the i2c register transaction sequencer: queued request and event beats,
// a local copy of the command sequencing and field-by-field checks of every result beat
// depends on i2c_rts_pkg, i2c_rts_if and i2c_register_transaction_sequencer
module i2c_register_transaction_sequencer_test;
  import i2c_rts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_ADDR_W, S_REG, S_DATA, S_RESTART, S_ADDR_R, S_RECV
  } xfer_phase_t;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} traffic_t;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst;

  i2c_rts_req_if req_ch();
  i2c_rts_res_if res_ch();

  i2c_register_transaction_sequencer u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  always #10 clk = ~clk;

  // expected sequencer state
  xfer_phase_t xfer_phase = S_IDLE;
  logic        xfer_read  = 1'b0;
  logic [7:0]  held_sla   = 8'h00;
  logic [7:0]  held_reg   = 8'h00;
  logic [7:0]  held_data  = 8'h00;

  item_t    req_backlog[$];
  result_t  cmd_expected[$];
  item_t    on_bus;
  traffic_t traffic = IDLE_NONE;
  int       mismatches = 0;
  int       useful_beats;

  function automatic result_t end_xfer(status_t code, logic [7:0] rdata);
    result_t r;
    r.command   = CMD_STOP;
    r.tx_byte   = 8'h00;
    r.done_res  = 1'b1;
    r.status    = code;
    r.read_data = rdata;
    xfer_phase  = S_IDLE;
    return r;
  endfunction

  task automatic predict_command(item_t it);
    result_t r;
    r.command   = CMD_NONE;
    r.tx_byte   = 8'h00;
    r.done_res  = 1'b0;
    r.status    = ST_OK;
    r.read_data = 8'h00;
    if (it.req_type == REQ_WRITE || it.req_type == REQ_READ) begin
      // a request while busy is dropped
      if (xfer_phase == S_IDLE) begin
        xfer_read  = (it.req_type == REQ_READ);
        held_sla   = it.slave_address;
        held_reg   = it.reg_address;
        held_data  = xfer_read ? 8'h00 : it.write_data;
        xfer_phase = S_START;
        r.command  = CMD_START;
      end
    end else if (it.req_type == REQ_EVENT) begin
      case (xfer_phase)
        S_START: begin
          if (it.bus_status != BUS_START_OK) begin
            r = end_xfer(ST_START_FAIL, 8'h00);
          end else begin
            xfer_phase = S_ADDR_W;
            r.command  = CMD_SEND;
            r.tx_byte  = held_sla;
          end
        end
        S_ADDR_W: begin
          if (it.bus_status == BUS_SLA_W_NACK) begin
            r = end_xfer(ST_ADDR_NACK, 8'h00);
          end else begin
            xfer_phase = S_REG;
            r.command  = CMD_SEND;
            r.tx_byte  = held_reg;
          end
        end
        S_REG: begin
          if (it.bus_status == BUS_DATA_NACK) begin
            r = end_xfer(ST_REG_NACK, 8'h00);
          end else if (xfer_read) begin
            xfer_phase = S_RESTART;
            r.command  = CMD_RESTART;
          end else begin
            xfer_phase = S_DATA;
            r.command  = CMD_SEND;
            r.tx_byte  = held_data;
          end
        end
        S_DATA: begin
          if (it.bus_status == BUS_DATA_NACK) r = end_xfer(ST_DATA_NACK, 8'h00);
          else r = end_xfer(ST_OK, 8'h00);
        end
        S_RESTART: begin
          if (it.bus_status != BUS_RESTART_OK) begin
            r = end_xfer(ST_RESTART_FAIL, 8'h00);
          end else begin
            xfer_phase = S_ADDR_R;
            r.command  = CMD_SEND;
            r.tx_byte  = held_sla | 8'h01;
          end
        end
        S_ADDR_R: begin
          if (it.bus_status == BUS_SLA_R_NACK) begin
            r = end_xfer(ST_RD_ADDR_NACK, 8'h00);
          end else begin
            xfer_phase = S_RECV;
            r.command  = CMD_RECV;
          end
        end
        S_RECV: r = end_xfer(ST_OK, it.received_byte);
        default: ;
      endcase
    end
    cmd_expected.push_back(r);
  endtask

  task automatic flag(string what, logic [7:0] want, logic [7:0] got);
    $display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
    mismatches++;
  endtask

  task automatic check_result();
    result_t want;
    if (cmd_expected.size() == 0) begin
      flag("result with nothing pending, command", 8'h00, 8'(res_ch.command));
    end else begin
      want = cmd_expected.pop_front();
      if (res_ch.command !== want.command)
        flag("command", 8'(want.command), 8'(res_ch.command));
      if (res_ch.tx_byte !== want.tx_byte) flag("tx_byte", want.tx_byte, res_ch.tx_byte);
      if (res_ch.done_res !== want.done_res)
        flag("done_res", 8'(want.done_res), 8'(res_ch.done_res));
      if (res_ch.status !== want.status)
        flag("status", 8'(want.status), 8'(res_ch.status));
      if (res_ch.read_data !== want.read_data)
        flag("read_data", want.read_data, res_ch.read_data);
    end
  endtask

  function automatic bit sender_idle();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    return (traffic == IDLE_SEND && roll < 86) || (traffic == IDLE_BOTH && roll < 19);
  endfunction

  function automatic bit receiver_stall();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    return (traffic == IDLE_RECV && roll < 86) || (traffic == IDLE_BOTH && roll < 19);
  endfunction

  // request side
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) predict_command(on_bus);
      if (!req_ch.valid || req_ch.ready) begin
        if (req_backlog.size() != 0 && !sender_idle()) begin
          on_bus = req_backlog.pop_front();
          req_ch.req_type      <= on_bus.req_type;
          req_ch.slave_address <= on_bus.slave_address;
          req_ch.reg_address   <= on_bus.reg_address;
          req_ch.write_data    <= on_bus.write_data;
          req_ch.bus_status    <= on_bus.bus_status;
          req_ch.received_byte <= on_bus.received_byte;
          req_ch.valid         <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) check_result();
      res_ch.ready <= !receiver_stall();
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] rand_not(logic [7:0] v);
    logic [7:0] x;
    x = rand_byte();
    if (x == v) x = ~v;
    return x;
  endfunction

  function automatic item_t make_beat(logic [1:0] kind, logic [7:0] sla, logic [7:0] regad,
                                      logic [7:0] dat, logic [7:0] bs, logic [7:0] rx);
    item_t it;
    it.req_type      = kind;
    it.slave_address = sla;
    it.reg_address   = regad;
    it.write_data    = dat;
    it.bus_status    = bs;
    it.received_byte = rx;
    return it;
  endfunction

  // beats the sequencer should drop: requests while busy, events while idle, unused type
  function automatic item_t noise_beat(bit busy);
    logic [1:0] kind;
    case ($urandom_range(0, 2))
      0:       kind = busy ? REQ_WRITE : REQ_EVENT;
      1:       kind = busy ? REQ_READ : REQ_EVENT;
      default: kind = REQ_UNUSED;
    endcase
    return make_beat(kind, rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte());
  endfunction

  // engine status that lets the given step pass or makes it fail
  function automatic logic [7:0] pick_status(xfer_phase_t p, bit fail);
    case (p)
      S_START:   return fail ? rand_not(BUS_START_OK) : BUS_START_OK;
      S_RESTART: return fail ? rand_not(BUS_RESTART_OK) : BUS_RESTART_OK;
      S_ADDR_W:  return fail ? BUS_SLA_W_NACK : rand_not(BUS_SLA_W_NACK);
      S_REG,
      S_DATA:    return fail ? BUS_DATA_NACK : rand_not(BUS_DATA_NACK);
      S_ADDR_R:  return fail ? BUS_SLA_R_NACK : rand_not(BUS_SLA_R_NACK);
      default:   return rand_byte();
    endcase
  endfunction

  // one request and its engine events, failing at fail_at (S_IDLE runs to the end)
  task automatic add_transaction(bit rd, xfer_phase_t fail_at, int noise_pct,
                                 logic [7:0] sla, logic [7:0] regad, logic [7:0] dat,
                                 logic [7:0] rx);
    xfer_phase_t p;
    bit          fail;
    req_backlog.push_back(make_beat(rd ? REQ_READ : REQ_WRITE, sla, regad, dat,
                                    rand_byte(), rand_byte()));
    useful_beats++;
    p = S_START;
    while (1) begin
      fail = (p == fail_at);
      req_backlog.push_back(make_beat(REQ_EVENT, rand_byte(), rand_byte(), rand_byte(),
                                      pick_status(p, fail), rx));
      useful_beats++;
      if (fail || p == S_DATA || p == S_RECV) break;
      if ($urandom_range(0, 99) < noise_pct) req_backlog.push_back(noise_beat(1'b1));
      case (p)
        S_START:   p = S_ADDR_W;
        S_ADDR_W:  p = S_REG;
        S_REG:     p = rd ? S_RESTART : S_DATA;
        S_RESTART: p = S_ADDR_R;
        default:   p = S_RECV;
      endcase
    end
  endtask

  // waits until every beat is out and every result is back
  task automatic settle();
    while (req_backlog.size() != 0 || req_ch.valid) @(negedge clk);
    while (cmd_expected.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    xfer_phase_t fail_at;
    req_ch.valid         = 1'b0;
    req_ch.req_type      = REQ_WRITE;
    req_ch.slave_address = 8'h00;
    req_ch.reg_address   = 8'h00;
    req_ch.write_data    = 8'h00;
    req_ch.bus_status    = 8'h00;
    req_ch.received_byte = 8'h00;
    res_ch.ready         = 1'b0;
    rst                  = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: idle event, unused type, full read and write, busy request, start/addr/reg failures
    req_backlog.push_back(make_beat(REQ_EVENT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    req_backlog.push_back(make_beat(REQ_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    add_transaction(1'b1, S_IDLE, 0, 8'hff, 8'hff, 8'hff, 8'hff);
    add_transaction(1'b0, S_IDLE, 0, 8'h00, 8'h00, 8'hff, 8'h00);
    req_backlog.push_back(make_beat(REQ_WRITE, 8'h5a, 8'ha5, 8'h3c, 8'h00, 8'h00));
    req_backlog.push_back(make_beat(REQ_READ, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    req_backlog.push_back(make_beat(REQ_EVENT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    add_transaction(1'b0, S_ADDR_W, 0, 8'h42, 8'h10, 8'h77, 8'h00);
    add_transaction(1'b1, S_REG, 0, 8'ha0, 8'h01, 8'h00, 8'h00);
    settle();

    for (int m = 0; m < 4; m++) begin
      traffic = traffic_t'(m);
      useful_beats = 0;
      while (useful_beats < 245) begin
        if ($urandom_range(0, 99) < 90) begin
          if ($urandom_range(0, 99) < 70) fail_at = S_IDLE;
          else fail_at = xfer_phase_t'($urandom_range(1, 7));
          add_transaction(1'($urandom_range(0, 1)), fail_at, 6, rand_byte(), rand_byte(),
                          rand_byte(), rand_byte());
        end else begin
          req_backlog.push_back(noise_beat(1'b0));
        end
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/i2c_rts_pkg.sv
rtl/i2c_rts_if.sv
rtl/i2c_rts_fsm.sv
rtl/i2c_rts_out_reg.sv
rtl/i2c_register_transaction_sequencer.sv
bench/i2c_register_transaction_sequencer_test.sv
